// ===== hdl/tnopt_pkg.sv =====
// Shared types and constants for the telnet option negotiator.
package tnopt_pkg;

   // Telnet command bytes
   localparam logic [7:0] B_IAC  = 8'd255;
   localparam logic [7:0] B_DONT = 8'd254;
   localparam logic [7:0] B_DO   = 8'd253;
   localparam logic [7:0] B_WONT = 8'd252;
   localparam logic [7:0] B_WILL = 8'd251;
   localparam logic [7:0] B_SB   = 8'd250;
   localparam logic [7:0] B_GA   = 8'd249;
   localparam logic [7:0] B_SE   = 8'd240;
   localparam logic [7:0] B_EOR  = 8'd239;
   localparam logic [7:0] B_NL   = 8'd10;

   // Option numbers
   localparam logic [7:0] OPT_ECHO    = 8'd1;
   localparam logic [7:0] OPT_SGA     = 8'd3;
   localparam logic [7:0] OPT_TTYPE   = 8'd24;
   localparam logic [7:0] OPT_EOR     = 8'd25;
   localparam logic [7:0] OPT_NAWS    = 8'd31;
   localparam logic [7:0] OPT_CHARSET = 8'd42;
   localparam logic [7:0] OPT_MCCP1   = 8'd85;
   localparam logic [7:0] OPT_MCCP2   = 8'd86;
   localparam logic [7:0] OPT_MSP     = 8'd90;
   localparam logic [7:0] OPT_MXP     = 8'd91;
   localparam logic [7:0] OPT_ZMP     = 8'd93;
   localparam logic [7:0] OPT_ATCP    = 8'd200;

   // Result kinds
   localparam logic [2:0] KIND_DATA  = 3'd0;
   localparam logic [2:0] KIND_REPLY = 3'd1;
   localparam logic [2:0] KIND_PAY   = 3'd2;
   localparam logic [2:0] KIND_END   = 3'd3;
   localparam logic [2:0] KIND_GA    = 3'd4;
   localparam logic [2:0] KIND_COMP  = 3'd5;
   localparam logic [2:0] KIND_DISC  = 3'd6;

   localparam logic [1:0] MCCP_NONE = 2'd0;
   localparam logic [1:0] MCCP_V1   = 2'd1;
   localparam logic [1:0] MCCP_V2   = 2'd2;

   // Sent-flag bits per option
   localparam int FLAG_W = 4;
   localparam logic [FLAG_W-1:0] F_DO   = 4'b0001;
   localparam logic [FLAG_W-1:0] F_DONT = 4'b0010;
   localparam logic [FLAG_W-1:0] F_WILL = 4'b0100;
   localparam logic [FLAG_W-1:0] F_WONT = 4'b1000;
   localparam int OPT_NUM = 256;
   localparam int OPT_W   = 8;

   // Subnegotiation payload counter
   localparam int CNT_W = 14;
   localparam logic [CNT_W-1:0] CNT_MAX = 14'd16383;

   // Configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GA_TO_NEWLINE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_ACCEPT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MXP_MODE        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NAWS_ENABLE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPRESS_ENABLE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ZMP_ENABLE      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ATCP_ENABLE     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MSP_ENABLE      = 3'd7;

   typedef struct packed {
      logic       ga_to_newline;
      logic       echo_accept;
      logic [1:0] mxp_mode;
      logic       naws_enable;
      logic       compress_enable;
      logic       zmp_enable;
      logic       atcp_enable;
      logic       msp_enable;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      ga_to_newline:   1'b0,
      echo_accept:     1'b1,
      mxp_mode:        2'd1,
      naws_enable:     1'b0,
      compress_enable: 1'b1,
      zmp_enable:      1'b0,
      atcp_enable:     1'b0,
      msp_enable:      1'b0
   };

   // Parser phase, one-hot
   typedef enum logic [10:0] {
      PH_NONE    = 11'b000_0000_0001,
      PH_IAC     = 11'b000_0000_0010,
      PH_WILL    = 11'b000_0000_0100,
      PH_WONT    = 11'b000_0000_1000,
      PH_DO      = 11'b000_0001_0000,
      PH_DONT    = 11'b000_0010_0000,
      PH_SB      = 11'b000_0100_0000,
      PH_SUB     = 11'b000_1000_0000,
      PH_SUB_IAC = 11'b001_0000_0000,
      PH_C1      = 11'b010_0000_0000,
      PH_C1_WILL = 11'b100_0000_0000
   } phase_type;

   // What a parsed request turns into
   typedef enum logic [2:0] {
      JOB_NONE,
      JOB_DATA,
      JOB_GA,
      JOB_PAY,
      JOB_END,
      JOB_DISC,
      JOB_C1,
      JOB_NEG
   } job_op_type;

   typedef struct packed {
      job_op_type op;
      logic [7:0] byte_val;  // data/payload byte, or reply command
      logic [7:0] opt;
      logic       nl;        // newline follows GA
      logic       echo;      // echo suppression after this request
   } job_type;

endpackage

// ===== hdl/tnopt_flag_mem.sv =====
// Per-option sent-flag memory: 256 x 4, one write and one registered read port.
module tnopt_flag_mem
   import tnopt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              we,
   input  logic [OPT_W-1:0]  waddr,
   input  logic [FLAG_W-1:0] wdata,
   input  logic              re,
   input  logic [OPT_W-1:0]  raddr,
   output logic [FLAG_W-1:0] rdata
);

   logic [FLAG_W-1:0]  mem [OPT_NUM];
   logic [OPT_NUM-1:0] valid_ff;
   logic [FLAG_W-1:0]  rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= valid_ff[raddr] ? mem[raddr] : '0;
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (we) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/tnopt_parse.sv =====
// Byte parser: telnet phase tracking, option policy and subnegotiation counting.
module tnopt_parse
   import tnopt_pkg::*;
#(
   parameter int SUBNEG_MAX = 8192
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output job_type    job_in
);

   phase_type        phase_ff, phase_in;
   logic [7:0]       sub_option_ff, sub_option_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             mccp2_ff, mccp2_in;
   logic             echo_off_ff, echo_off_in;
   logic             will_yes, do_yes;
   logic             below_max;

   assign below_max = count_ff < CNT_W'(SUBNEG_MAX);

   always_comb begin
      unique case (rx_byte)
         OPT_MCCP1:   will_yes = cfg.compress_enable && !mccp2_ff;
         OPT_MCCP2:   will_yes = cfg.compress_enable;
         OPT_SGA,
         OPT_CHARSET: will_yes = 1'b1;
         OPT_ECHO:    will_yes = cfg.echo_accept;
         OPT_MXP:     will_yes = cfg.mxp_mode != 2'd0;
         OPT_EOR:     will_yes = cfg.ga_to_newline;
         OPT_ZMP:     will_yes = cfg.zmp_enable;
         OPT_ATCP:    will_yes = cfg.atcp_enable;
         OPT_MSP:     will_yes = cfg.msp_enable;
         default:     will_yes = 1'b0;
      endcase
   end

   always_comb begin
      unique case (rx_byte)
         OPT_SGA,
         OPT_ECHO,
         OPT_CHARSET,
         OPT_TTYPE:   do_yes = 1'b1;
         OPT_NAWS:    do_yes = cfg.naws_enable;
         OPT_MXP:     do_yes = cfg.mxp_mode != 2'd0;
         default:     do_yes = 1'b0;
      endcase
   end

   always_comb begin
      phase_in      = PH_NONE;
      sub_option_in = sub_option_ff;
      count_in      = count_ff;
      mccp2_in      = mccp2_ff;
      echo_off_in   = echo_off_ff;
      job_in.op       = JOB_NONE;
      job_in.byte_val = rx_byte;
      job_in.opt      = sub_option_ff;
      job_in.nl       = cfg.ga_to_newline;

      unique case (phase_ff)
         PH_IAC: begin
            sub_option_in = '0;
            job_in.opt    = '0;
            unique case (rx_byte)
               B_EOR,
               B_GA:    job_in.op = JOB_GA;
               B_SB:    phase_in = PH_SB;
               B_WILL:  phase_in = PH_WILL;
               B_WONT:  phase_in = PH_WONT;
               B_DO:    phase_in = PH_DO;
               B_DONT:  phase_in = PH_DONT;
               B_IAC:   job_in.op = JOB_DATA;
               default: job_in.op = JOB_NONE;
            endcase
         end
         PH_WILL: begin
            job_in.op       = JOB_NEG;
            job_in.opt      = rx_byte;
            job_in.byte_val = will_yes ? B_DO : B_DONT;
            if (will_yes && rx_byte == OPT_MCCP2) begin
               mccp2_in = 1'b1;
            end
            if (will_yes && rx_byte == OPT_ECHO) begin
               echo_off_in = 1'b1;
            end
         end
         PH_WONT: begin
            job_in.op       = JOB_NEG;
            job_in.opt      = rx_byte;
            job_in.byte_val = B_DONT;
            if (rx_byte == OPT_ECHO && cfg.echo_accept) begin
               echo_off_in = 1'b0;
            end
         end
         PH_DO: begin
            job_in.op       = JOB_NEG;
            job_in.opt      = rx_byte;
            job_in.byte_val = do_yes ? B_WILL : B_WONT;
         end
         PH_DONT: begin
            job_in.op       = JOB_NEG;
            job_in.opt      = rx_byte;
            job_in.byte_val = B_WONT;
         end
         PH_SB: begin
            if (rx_byte == OPT_MCCP1) begin
               phase_in = PH_C1;
            end else begin
               sub_option_in = rx_byte;
               count_in      = '0;
               phase_in      = PH_SUB;
            end
         end
         PH_SUB: begin
            if (rx_byte == B_IAC) begin
               phase_in = PH_SUB_IAC;
            end else if (below_max) begin
               count_in  = count_ff + 1'b1;
               phase_in  = PH_SUB;
               job_in.op = JOB_PAY;
            end else begin
               count_in  = '0;
               job_in.op = JOB_DISC;
            end
         end
         PH_SUB_IAC: begin
            if (rx_byte == B_IAC) begin
               if (count_ff != CNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
               phase_in  = PH_SUB;
               job_in.op = JOB_PAY;
            end else begin
               job_in.op = JOB_END;
            end
         end
         PH_C1: begin
            phase_in = (rx_byte == B_WILL) ? PH_C1_WILL : PH_NONE;
         end
         PH_C1_WILL: begin
            if (rx_byte == B_SE) begin
               job_in.op = JOB_C1;
            end
         end
         default: begin
            // plain data, and any phase code that means nothing
            if (rx_byte == B_IAC) begin
               phase_in = PH_IAC;
            end else begin
               job_in.op = JOB_DATA;
            end
         end
      endcase

      job_in.echo = echo_off_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_NONE;
         sub_option_ff <= '0;
         count_ff      <= '0;
         mccp2_ff      <= 1'b0;
         echo_off_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         sub_option_ff <= sub_option_in;
         count_ff      <= count_in;
         mccp2_ff      <= mccp2_in;
         echo_off_ff   <= echo_off_in;
      end
   end

endmodule

// ===== hdl/tnopt_reply.sv =====
// Reply stage: sent-flag read-modify-write and the result output register.
module tnopt_reply
   import tnopt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  job_type    job_in,
   input  logic [7:0] rx_byte,
   output logic       job_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_value,
   output logic [7:0] rsp_option_code,
   output logic [1:0] rsp_mccp_version,
   output logic       rsp_echo_suppressed,
   output logic       rsp_last
);

   job_type           job_ff;
   logic              job_valid_ff;
   logic              fwd_ff;
   logic [FLAG_W-1:0] fwd_data_ff;
   job_type           em_ff;
   logic [1:0]        em_left_ff;
   logic [1:0]        em_idx_ff;

   logic [FLAG_W-1:0] rd_data, cur_flags, set_mask, clr_mask, wdata;
   logic              mem_we, dup, deliver, em_free, xfer;
   logic [1:0]        job_cnt;

   tnopt_flag_mem u_flag_mem (
      .clock (clock),
      .reset (reset),
      .we    (mem_we),
      .waddr (job_ff.opt),
      .wdata (wdata),
      .re    (accept),
      .raddr (rx_byte),
      .rdata (rd_data)
   );

   always_comb begin
      unique case (job_ff.byte_val)
         B_DO: begin
            set_mask = F_DO;
            clr_mask = F_DONT;
         end
         B_DONT: begin
            set_mask = F_DONT;
            clr_mask = F_DO;
         end
         B_WILL: begin
            set_mask = F_WILL;
            clr_mask = F_WONT;
         end
         default: begin
            set_mask = F_WONT;
            clr_mask = F_WILL;
         end
      endcase
   end

   // a write in the cycle of the read is not seen by the memory output
   assign cur_flags = fwd_ff ? fwd_data_ff : rd_data;
   assign dup       = (cur_flags & set_mask) != '0;
   assign wdata     = (cur_flags | set_mask) & ~clr_mask;

   always_comb begin
      unique case (job_ff.op)
         JOB_NONE: job_cnt = 2'd0;
         JOB_GA:   job_cnt = job_ff.nl ? 2'd2 : 2'd1;
         JOB_END:  job_cnt = (job_ff.opt == OPT_MCCP2) ? 2'd2 : 2'd1;
         JOB_NEG:  job_cnt = dup ? 2'd0 : 2'd3;
         default:  job_cnt = 2'd1;
      endcase
   end

   assign rsp_valid = em_left_ff != 2'd0;
   assign rsp_last  = em_left_ff == 2'd1;
   assign deliver   = rsp_valid && !rsp_stall;
   assign em_free   = !rsp_valid || (deliver && rsp_last);
   assign xfer      = job_valid_ff && em_free;
   assign job_ready = !job_valid_ff || xfer;
   assign mem_we    = xfer && job_ff.op == JOB_NEG && !dup;

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else if (accept) begin
         job_valid_ff <= 1'b1;
      end else if (xfer) begin
         job_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff      <= job_in;
         fwd_ff      <= mem_we && job_ff.opt == rx_byte;
         fwd_data_ff <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_left_ff <= '0;
         em_idx_ff  <= '0;
      end else if (xfer) begin
         em_left_ff <= job_cnt;
         em_idx_ff  <= '0;
      end else if (deliver) begin
         em_left_ff <= em_left_ff - 1'b1;
         em_idx_ff  <= em_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (xfer) begin
         em_ff <= job_ff;
      end
   end

   always_comb begin
      rsp_kind         = KIND_DATA;
      rsp_value        = '0;
      rsp_option_code  = '0;
      rsp_mccp_version = MCCP_NONE;
      unique case (em_ff.op)
         JOB_DATA: begin
            rsp_value = em_ff.byte_val;
         end
         JOB_GA: begin
            if (em_idx_ff == 2'd0) begin
               rsp_kind = KIND_GA;
            end else begin
               rsp_value = B_NL;
            end
         end
         JOB_PAY: begin
            rsp_kind        = KIND_PAY;
            rsp_value       = em_ff.byte_val;
            rsp_option_code = em_ff.opt;
         end
         JOB_END: begin
            if (em_idx_ff == 2'd0) begin
               rsp_kind        = KIND_END;
               rsp_option_code = em_ff.opt;
            end else begin
               rsp_kind         = KIND_COMP;
               rsp_option_code  = OPT_MCCP2;
               rsp_mccp_version = MCCP_V2;
            end
         end
         JOB_DISC: begin
            rsp_kind        = KIND_DISC;
            rsp_option_code = em_ff.opt;
         end
         JOB_C1: begin
            rsp_kind         = KIND_COMP;
            rsp_option_code  = OPT_MCCP1;
            rsp_mccp_version = MCCP_V1;
         end
         JOB_NEG: begin
            rsp_kind        = KIND_REPLY;
            rsp_option_code = em_ff.opt;
            if (em_idx_ff == 2'd0) begin
               rsp_value = B_IAC;
            end else if (em_idx_ff == 2'd1) begin
               rsp_value = em_ff.byte_val;
            end else begin
               rsp_value = em_ff.opt;
            end
         end
         default: begin
            rsp_kind = KIND_DATA;
         end
      endcase
   end

   assign rsp_echo_suppressed = em_ff.echo;

   // only a negotiation reply spans three results
   a_three_only_neg: assert property (@(posedge clock) disable iff (reset)
      em_left_ff == 2'd3 |-> em_ff.op == JOB_NEG)
      else $error("three results pending for a non-reply request");

   // a reply starts with IAC
   a_reply_iac_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_REPLY && em_idx_ff == 2'd0 |-> rsp_value == B_IAC)
      else $error("reply does not start with IAC");

   // written flags hold the answer sent and never its opposite
   a_flag_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (wdata & set_mask) != '0 && (wdata & clr_mask) == '0)
      else $error("sent-flag write is inconsistent");

   // a waiting request moves into the output register once the last result leaves
   a_hand_on: assert property (@(posedge clock) disable iff (reset)
      deliver && rsp_last && job_valid_ff |=> em_idx_ff == 2'd0)
      else $error("pending request not moved to output");

endmodule

// ===== hdl/telnet_option_negotiator.sv =====
// Telnet receive deframer with option negotiation, top level.
// A request passes the job register, then the output register, before its
// first result is valid. Throughput: one request per cycle while each yields
// at most one result and rsp_stall is low; a negotiation answer has three
// results from the single result register. Reset (synchronous): parser idle,
// sent-flag valid bits, config defaults restored; no flag memory clearing pass.
module telnet_option_negotiator
   import tnopt_pkg::*;
#(
   parameter int SUBNEG_MAX = 8192
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_kind,
   output logic [7:0]            rsp_value,
   output logic [7:0]            rsp_option_code,
   output logic [1:0]            rsp_mccp_version,
   output logic                  rsp_echo_suppressed,
   output logic                  rsp_last,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg_ff;
   job_type job_in;
   logic    job_ready;
   logic    accept;

   assign req_stall = !job_ready;
   assign accept    = req_valid && job_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GA_TO_NEWLINE:   cfg_ff.ga_to_newline   <= csr_data[0];
            CSR_ECHO_ACCEPT:     cfg_ff.echo_accept     <= csr_data[0];
            CSR_MXP_MODE:        cfg_ff.mxp_mode        <= csr_data;
            CSR_NAWS_ENABLE:     cfg_ff.naws_enable     <= csr_data[0];
            CSR_COMPRESS_ENABLE: cfg_ff.compress_enable <= csr_data[0];
            CSR_ZMP_ENABLE:      cfg_ff.zmp_enable      <= csr_data[0];
            CSR_ATCP_ENABLE:     cfg_ff.atcp_enable     <= csr_data[0];
            CSR_MSP_ENABLE:      cfg_ff.msp_enable      <= csr_data[0];
            default:             cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   tnopt_parse #(
      .SUBNEG_MAX (SUBNEG_MAX)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .cfg     (cfg_ff),
      .job_in  (job_in)
   );

   tnopt_reply u_reply (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .job_in              (job_in),
      .rx_byte             (req_rx_byte),
      .job_ready           (job_ready),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_value           (rsp_value),
      .rsp_option_code     (rsp_option_code),
      .rsp_mccp_version    (rsp_mccp_version),
      .rsp_echo_suppressed (rsp_echo_suppressed),
      .rsp_last            (rsp_last)
   );

endmodule
